### src/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// Character LCD 4-bit sequencer package
// Request kinds, display command bytes, hold times and the shared types of
// the sequencer and its pin-state generator.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  // Request kinds.
  localparam logic [2:0] KIND_INIT   = 3'd0;
  localparam logic [2:0] KIND_CMD    = 3'd1;
  localparam logic [2:0] KIND_DATA   = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_CURSOR = 3'd4;

  // Display command bytes and nibbles.
  localparam logic [7:0] CMD_LINE0_BASE = 8'h80;
  localparam logic [7:0] CMD_LINE1_BASE = 8'hC0;
  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [3:0] NIB_WAKE       = 4'h3;
  localparam logic [3:0] NIB_4BIT       = 4'h2;

  // Extra hold times in microseconds on the final state of a segment.
  localparam int unsigned TailW = 13;
  localparam logic [TailW-1:0] TAIL_CMD    = 13'd2000;
  localparam logic [TailW-1:0] TAIL_DATA   = 13'd1000;
  localparam logic [TailW-1:0] TAIL_CLEAR  = 13'd4000;
  localparam logic [TailW-1:0] TAIL_CURSOR = 13'd3000;
  localparam logic [TailW-1:0] TAIL_WAKE0  = 13'd5000;
  localparam logic [TailW-1:0] TAIL_WAKE   = 13'd150;
  localparam logic [15:0]      HOLD_POWER  = 16'd50000;
  localparam logic [15:0]      HOLD_BASE   = 16'd1;

  // Init is split into segments: power-up wait, four wake nibbles, four bytes.
  localparam int unsigned SegW = 4;
  localparam logic [SegW-1:0] SEG_INIT_LAST = 4'd8;
  localparam logic [2:0]      POS_NIB_LAST  = 3'd2;
  localparam logic [2:0]      POS_BYTE_LAST = 3'd6;

  typedef enum logic [1:0] {
    SEG_POWER,
    SEG_NIBBLE,
    SEG_BYTE
  } seg_kind_e;

  // Latched request.
  typedef struct packed {
    logic             init;
    logic             rs;
    logic [7:0]       value;
    logic [TailW-1:0] tail;
  } req_t;

  // One pin state with its hold time.
  typedef struct packed {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [15:0] hold;
    logic        last;
  } pin_t;

endpackage

### src/lcdseq_state_gen.sv
// ----------------------------------------------------------------------------
// Character LCD 4-bit sequencer pin-state generator
// Maps the latched request, segment and position to one pin state.
// ----------------------------------------------------------------------------
module lcdseq_state_gen (
  input  lcdseq_pkg::req_t            req_i,
  input  logic [lcdseq_pkg::SegW-1:0] seg_i,
  input  logic [2:0]                  pos_i,
  input  logic                        rs_level_i,
  input  logic [3:0]                  data_level_i,
  output lcdseq_pkg::pin_t            pin_o,
  output logic                        seg_end_o
);
  import lcdseq_pkg::*;

  seg_kind_e        seg_kind;
  logic [7:0]       seg_value;
  logic             seg_rs;
  logic [TailW-1:0] seg_tail;
  logic [15:0]      tail_hold;

  // Segment descriptor: init walks a fixed list, other requests are one byte.
  always_comb begin
    seg_kind  = SEG_BYTE;
    seg_value = req_i.value;
    seg_rs    = req_i.rs;
    seg_tail  = req_i.tail;
    if (req_i.init) begin
      seg_rs = 1'b0;
      case (seg_i)
        4'd0: begin
          seg_kind  = SEG_POWER;
          seg_value = 8'h00;
          seg_tail  = '0;
        end
        4'd1: begin
          seg_kind  = SEG_NIBBLE;
          seg_value = {4'h0, NIB_WAKE};
          seg_tail  = TAIL_WAKE0;
        end
        4'd2, 4'd3: begin
          seg_kind  = SEG_NIBBLE;
          seg_value = {4'h0, NIB_WAKE};
          seg_tail  = TAIL_WAKE;
        end
        4'd4: begin
          seg_kind  = SEG_NIBBLE;
          seg_value = {4'h0, NIB_4BIT};
          seg_tail  = TAIL_WAKE;
        end
        4'd5: begin
          seg_value = CMD_FUNC_SET;
          seg_tail  = TAIL_CMD;
        end
        4'd6: begin
          seg_value = CMD_DISP_ON;
          seg_tail  = TAIL_CMD;
        end
        4'd7: begin
          seg_value = CMD_ENTRY_MODE;
          seg_tail  = TAIL_CMD;
        end
        4'd8: begin
          seg_value = CMD_CLEAR;
          seg_tail  = TAIL_CLEAR;
        end
        default: begin
          seg_kind  = SEG_POWER;
          seg_value = 8'h00;
          seg_tail  = '0;
        end
      endcase
    end
  end

  assign tail_hold = HOLD_BASE + {{(16-TailW){1'b0}}, seg_tail};

  // Pin state for the current position within the segment.
  always_comb begin
    pin_o.rs   = rs_level_i;
    pin_o.en   = 1'b0;
    pin_o.nib  = data_level_i;
    pin_o.hold = HOLD_BASE;
    seg_end_o  = 1'b0;
    case (seg_kind)
      SEG_POWER: begin
        pin_o.rs   = 1'b0;
        pin_o.nib  = 4'h0;
        pin_o.hold = HOLD_POWER;
        seg_end_o  = 1'b1;
      end
      SEG_NIBBLE: begin
        pin_o.nib = seg_value[3:0];
        pin_o.en  = (pos_i == 3'd1);
        seg_end_o = (pos_i == POS_NIB_LAST);
        if (seg_end_o) begin
          pin_o.hold = tail_hold;
        end
      end
      SEG_BYTE: begin
        // Select level first, then high and low nibble with an enable pulse.
        pin_o.rs  = seg_rs;
        pin_o.nib = (pos_i == 3'd0) ? data_level_i :
                    (pos_i <= 3'd3) ? seg_value[7:4] : seg_value[3:0];
        pin_o.en  = (pos_i == 3'd2) || (pos_i == 3'd5);
        seg_end_o = (pos_i == POS_BYTE_LAST);
        if (seg_end_o) begin
          pin_o.hold = tail_hold;
        end
      end
      default: begin
        seg_end_o = 1'b1;
      end
    endcase
    pin_o.last = seg_end_o && (!req_i.init || (seg_i == SEG_INIT_LAST));
  end

endmodule

### src/char_lcd_4bit_interface_sequencer.sv
// ----------------------------------------------------------------------------
// Character LCD 4-bit interface sequencer
// Turns display requests into timed pin states for an HD44780-style panel.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (in_valid_i/in_ready_o) takes one request: init,
//   command byte, data byte, clear or set cursor. The result channel
//   (out_valid_o/out_ready_i) delivers one pin state per transfer with the
//   hold time in microseconds that a timer applies before the next state.
//   last_of_run_o marks the final state of each request.
//   A byte request gives 7 states, init gives 41. The generator emits one
//   state per cycle into an output register while the receiver does not
//   stall. A taken request is registered first, then its states pass
//   through the output register. The next request is taken in the cycle
//   the last state of the current one is generated, before that state is
//   delivered. The rate is set by the single pin-state generator, one state per cycle.
//   Requests with an unknown kind are taken and produce nothing.
//   When the receiver stalls, the output register holds its state and the
//   generator waits. Reset clears the run and sets the kept register select
//   and data levels to zero.
// ----------------------------------------------------------------------------
module char_lcd_4bit_interface_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  byte_value_i,
  input  logic        cursor_row_i,
  input  logic [5:0]  cursor_col_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        reg_select_o,
  output logic        enable_pin_o,
  output logic [3:0]  data_nibble_o,
  output logic [15:0] hold_us_o,
  output logic        last_of_run_o
);
  import lcdseq_pkg::*;

  logic            busy_q, busy_d;
  req_t            req_q, req_d;
  logic [SegW-1:0] seg_q, seg_d;
  logic [2:0]      pos_q, pos_d;
  logic            rs_level_q, rs_level_d;
  logic [3:0]      data_level_q, data_level_d;
  logic            out_valid_q, out_valid_d;
  pin_t            pin_q;
  pin_t            pin;
  logic            seg_end;
  logic            gen_fire;
  logic            in_fire;
  req_t            req_new;
  logic            req_new_valid;

  // Pin-state generator for the current segment and position.
  lcdseq_state_gen u_state_gen (
    .req_i        (req_q),
    .seg_i        (seg_q),
    .pos_i        (pos_q),
    .rs_level_i   (rs_level_q),
    .data_level_i (data_level_q),
    .pin_o        (pin),
    .seg_end_o    (seg_end)
  );

  // Handshake: generate when the output register is free or being drained.
  assign gen_fire   = busy_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy_q || (gen_fire && pin.last);
  assign in_fire    = in_valid_i && in_ready_o;

  // Decode the incoming request into a byte, select level and tail hold.
  always_comb begin
    req_new_valid = 1'b1;
    req_new.init  = 1'b0;
    req_new.rs    = 1'b0;
    req_new.value = byte_value_i;
    req_new.tail  = TAIL_CMD;
    case (kind_i)
      KIND_INIT: begin
        req_new.init = 1'b1;
      end
      KIND_CMD: begin
        req_new.tail = TAIL_CMD;
      end
      KIND_DATA: begin
        req_new.rs   = 1'b1;
        req_new.tail = TAIL_DATA;
      end
      KIND_CLEAR: begin
        req_new.value = CMD_CLEAR;
        req_new.tail  = TAIL_CLEAR;
      end
      KIND_CURSOR: begin
        req_new.value = (cursor_row_i ? CMD_LINE1_BASE : CMD_LINE0_BASE)
                        + {2'b00, cursor_col_i};
        req_new.tail  = TAIL_CURSOR;
      end
      default: begin
        req_new_valid = 1'b0;
      end
    endcase
  end

  // Run control, kept pin levels and output register valid.
  always_comb begin
    busy_d       = busy_q;
    req_d        = req_q;
    seg_d        = seg_q;
    pos_d        = pos_q;
    rs_level_d   = rs_level_q;
    data_level_d = data_level_q;
    out_valid_d  = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (gen_fire) begin
      out_valid_d  = 1'b1;
      rs_level_d   = pin.rs;
      data_level_d = pin.nib;
      if (pin.last) begin
        busy_d = 1'b0;
      end else if (seg_end) begin
        seg_d = seg_q + 1'b1;
        pos_d = 3'd0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
    if (in_fire) begin
      busy_d = req_new_valid;
      req_d  = req_new;
      seg_d  = '0;
      pos_d  = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      seg_q        <= '0;
      pos_q        <= 3'd0;
      rs_level_q   <= 1'b0;
      data_level_q <= 4'h0;
      out_valid_q  <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      seg_q        <= seg_d;
      pos_q        <= pos_d;
      rs_level_q   <= rs_level_d;
      data_level_q <= data_level_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (gen_fire) begin
      pin_q <= pin;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign reg_select_o  = pin_q.rs;
  assign enable_pin_o  = pin_q.en;
  assign data_nibble_o = pin_q.nib;
  assign hold_us_o     = pin_q.hold;
  assign last_of_run_o = pin_q.last;

  // A run never ends with the enable strobe high.
  a_last_enable_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(last_of_run_o && enable_pin_o))
    else $error("run ended with enable high");

  // Requests other than init use only the first segment.
  a_single_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_q.init) |-> (seg_q == '0))
    else $error("segment advanced on a single-byte request");

  // The position never runs past the end of a byte segment.
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pos_q <= POS_BYTE_LAST))
    else $error("position out of range");

  // A generated state is visible at the output in the next cycle.
  a_gen_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_fire |=> out_valid_o)
    else $error("generated state not presented");

endmodule
